>>> src/mabtr_pkg.sv
// ----------------------------------------------------------------------------
// mabtr_pkg: shared constants and types
// Widths, reset values and the controller/datapath command structs for the
// moving average band trailing reference block.
// ----------------------------------------------------------------------------
package mabtr_pkg;

   localparam int NUM_SERIES_DEF = 128;
   localparam int MAX_WINDOW_DEF = 64;

   localparam int PRICE_W = 32;
   localparam int SUM_W   = 38;
   localparam int REF_W   = 33;
   localparam int WIN_W   = 7;
   localparam int BAND_W  = 16;
   localparam int SIDX_W  = 7;

   localparam logic [WIN_W-1:0]  WINDOW_RESET = 7'd15;
   localparam logic [BAND_W-1:0] BAND_RESET   = 16'd655;

   typedef enum logic [0:0] {
      CSR_WINDOW_DAYS   = 1'b0,
      CSR_BAND_FRACTION = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the accepted item, start state reads
      logic div_start; // start the sum divider
      logic band_mul;  // form the band products from the quotient
      logic commit;    // write state back and load the result register
      logic clr_step;  // clear one series entry during a clearing pass
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic need_div;  // item falls into a started or just-full series
      logic clr_last;
   } dp_sts_type;

endpackage

>>> src/mabtr_ctrl.sv
// ----------------------------------------------------------------------------
// mabtr_ctrl: sequencing state machine
// Steps one item through read, divide, band multiply and commit, and runs
// the clearing pass after reset or a window write.
// ----------------------------------------------------------------------------
module mabtr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   rsp_full,
   input  logic                   clear_req,
   input  mabtr_pkg::dp_sts_type  sts,
   output logic                   req_ready,
   output mabtr_pkg::dp_cmd_type  cmd
);
   import mabtr_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DIV, ST_WAIT, ST_BAND, ST_COMMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            // The dropped price is valid from here on.
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (!sts.div_busy) begin
               cmd.band_mul = 1'b1;
               state_in     = ST_BAND;
            end
         end
         ST_BAND: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!rsp_full) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (clear_req) begin
         state_in = ST_CLEAR;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !clear_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/mabtr_dpath.sv
// ----------------------------------------------------------------------------
// mabtr_dpath: per-series state and arithmetic
// Holds the price ring memory, the per-series state memory, a restoring
// divider for the window average and the band multipliers.
// ----------------------------------------------------------------------------
module mabtr_dpath #(
   parameter int NUM_SERIES = mabtr_pkg::NUM_SERIES_DEF,
   parameter int MAX_WINDOW = mabtr_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mabtr_pkg::dp_cmd_type          cmd,
   output mabtr_pkg::dp_sts_type          sts,
   input  logic [mabtr_pkg::SIDX_W-1:0]   in_series,
   input  logic [mabtr_pkg::PRICE_W-1:0]  in_price,
   input  logic [mabtr_pkg::WIN_W-1:0]    window_days,
   input  logic [mabtr_pkg::BAND_W-1:0]   band_fraction,
   input  logic                           rsp_take,
   output logic                           rsp_full,
   output logic                           out_valid,
   output logic                           out_ref_valid,
   output logic [mabtr_pkg::REF_W-1:0]    out_level,
   output logic                           out_sold
);
   import mabtr_pkg::*;

   localparam int SER_W  = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;
   localparam int HEAD_W = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
   localparam int RING_D = NUM_SERIES * (1 << HEAD_W);
   localparam int ACC_W  = PRICE_W + HEAD_W;
   localparam int QUO_W  = ACC_W;
   localparam int PROD_W = QUO_W + BAND_W + 1;
   localparam logic [REF_W-1:0] REF_MAX = '1;

   // Per-series state word.
   typedef struct packed {
      logic [ACC_W-1:0]  sum;
      logic [CNT_W-1:0]  cnt;
      logic [HEAD_W-1:0] head;
      logic              sold;
      logic [REF_W-1:0]  ref_lvl;
   } ser_type;

   ser_type                 ser_mem [NUM_SERIES];
   logic [PRICE_W-1:0]      ring_mem [RING_D];

   // Effective window.
   logic [CNT_W-1:0] win;
   always_comb begin
      if (window_days == '0) begin
         win = CNT_W'(1);
      end else if ({25'd0, window_days} > 32'(MAX_WINDOW)) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(window_days);
      end
   end

   // Item capture.
   logic [SER_W-1:0]   ser_ff;
   logic               oor_ff;
   logic [PRICE_W-1:0] price_ff;
   ser_type            st_ff;
   logic [PRICE_W-1:0] drop_ff;
   logic [SER_W-1:0]   clr_ff;

   logic in_oor;
   assign in_oor = ({25'd0, in_series} >= 32'(NUM_SERIES));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ser_ff   <= SER_W'(in_series);
         oor_ff   <= in_oor;
         price_ff <= in_price;
      end
   end

   // State read at the load edge and held for the rest of the item.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         st_ff <= ser_mem[SER_W'(in_series)];
      end
   end

   logic [HEAD_W-1:0] head_eff;
   assign head_eff = ({1'b0, st_ff.head} >= (HEAD_W+1)'(win)) ? '0 : st_ff.head;

   // Ring read: issued in ST_READ, valid from ST_DIV on.
   always_ff @(posedge clock) begin
      drop_ff <= ring_mem[{ser_ff, head_eff}];
   end

   logic full_now, started;
   assign full_now = (st_ff.cnt == win);
   assign started  = (st_ff.cnt > win);

   assign sts.need_div   = !oor_ff && (full_now || started);
   assign sts.clr_last   = (clr_ff == SER_W'(NUM_SERIES - 1));

   always_ff @(posedge clock) begin
      if (reset || !cmd.clr_step) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_ff + SER_W'(1);
      end
   end

   // Restoring divider, one quotient bit per cycle, one or two divisions: the
   // previous window sum (first full item only) and the slid sum.
   logic [ACC_W-1:0] new_sum;
   assign new_sum = st_ff.sum + ACC_W'(price_ff) - ACC_W'(drop_ff);

   logic              div_busy_ff, div_second_ff;
   logic [5:0]        div_cnt_ff;
   logic [ACC_W-1:0]  div_num_ff;
   logic [CNT_W:0]    div_rem_ff;
   logic [QUO_W-1:0]  avg_old_ff, avg_new_ff;
   logic [CNT_W:0]    rem_sh;
   logic              rem_ge;

   assign rem_sh = {div_rem_ff[CNT_W-1:0], div_num_ff[ACC_W-1]};
   assign rem_ge = (rem_sh >= (CNT_W+1)'(win));

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff   <= 1'b1;
         div_second_ff <= !full_now;
         div_cnt_ff    <= 6'(ACC_W - 1);
         div_num_ff    <= full_now ? st_ff.sum : new_sum;
         div_rem_ff    <= '0;
      end else if (div_busy_ff) begin
         div_rem_ff <= rem_ge ? rem_sh - (CNT_W+1)'(win) : rem_sh;
         div_num_ff <= {div_num_ff[ACC_W-2:0], rem_ge};
         if (div_cnt_ff == '0) begin
            if (!div_second_ff) begin
               avg_old_ff    <= {div_num_ff[ACC_W-2:0], rem_ge};
               div_second_ff <= 1'b1;
               div_cnt_ff    <= 6'(ACC_W - 1);
               div_num_ff    <= new_sum;
               div_rem_ff    <= '0;
            end else begin
               avg_new_ff  <= {div_num_ff[ACC_W-2:0], rem_ge};
               div_busy_ff <= 1'b0;
            end
         end else begin
            div_cnt_ff <= div_cnt_ff - 6'd1;
         end
      end
   end
   assign sts.div_busy = div_busy_ff;

   function automatic logic [REF_W-1:0] sat_ref(input logic [PROD_W-1:0] p);
      logic [PROD_W-17:0] s;
      s = p[PROD_W-1:16];
      return (s > (PROD_W-16)'(REF_MAX)) ? REF_MAX : REF_W'(s);
   endfunction

   // Band products, registered.
   logic [BAND_W:0]   f_up, f_dn;
   logic [REF_W-1:0]  old_up_ff, new_up_ff, new_dn_ff, old_dn_ff;
   assign f_up = {1'b1, 16'd0} + (BAND_W+1)'(band_fraction);
   assign f_dn = {1'b1, 16'd0} - (BAND_W+1)'(band_fraction);

   always_ff @(posedge clock) begin
      if (cmd.band_mul) begin
         old_up_ff <= sat_ref(PROD_W'(avg_old_ff) * PROD_W'(f_up));
         old_dn_ff <= sat_ref(PROD_W'(avg_old_ff) * PROD_W'(f_dn));
         new_up_ff <= sat_ref(PROD_W'(avg_new_ff) * PROD_W'(f_up));
         new_dn_ff <= sat_ref(PROD_W'(avg_new_ff) * PROD_W'(f_dn));
      end
   end

   // Decision.
   logic             sold0, sold1, q_lt_avg;
   logic [REF_W-1:0] ref0, ref1;
   ser_type          st_wr;
   assign q_lt_avg = (QUO_W'(price_ff) < avg_old_ff);

   always_comb begin
      sold0 = full_now ? q_lt_avg : st_ff.sold;
      ref0  = full_now ? (q_lt_avg ? old_up_ff : old_dn_ff) : st_ff.ref_lvl;
      if (sold0) begin
         if (REF_W'(price_ff) > ref0) begin
            sold1 = 1'b0;
            ref1  = new_dn_ff;
         end else begin
            sold1 = 1'b1;
            ref1  = (new_up_ff < ref0) ? new_up_ff : ref0;
         end
      end else begin
         if (REF_W'(price_ff) < ref0) begin
            sold1 = 1'b1;
            ref1  = new_up_ff;
         end else begin
            sold1 = 1'b0;
            ref1  = (new_dn_ff > ref0) ? new_dn_ff : ref0;
         end
      end
      st_wr      = st_ff;
      st_wr.head = (HEAD_W+1)'(head_eff) + 1'b1 == (HEAD_W+1)'(win) ?
                   '0 : head_eff + HEAD_W'(1);
      if (sts.need_div) begin
         st_wr.sum     = new_sum;
         st_wr.cnt     = win + CNT_W'(1);
         st_wr.sold    = sold1;
         st_wr.ref_lvl = ref1;
      end else begin
         st_wr.sum = st_ff.sum + ACC_W'(price_ff);
         st_wr.cnt = st_ff.cnt + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         ser_mem[clr_ff] <= '0;
      end else if (cmd.commit && !oor_ff) begin
         ser_mem[ser_ff] <= st_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !oor_ff) begin
         ring_mem[{ser_ff, head_eff}] <= price_ff;
      end
   end

   // Output register.
   logic             full_ff, vld_ff, sold_ff;
   logic [REF_W-1:0] lvl_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (cmd.commit) begin
         full_ff <= 1'b1;
      end else if (rsp_take) begin
         full_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         vld_ff  <= sts.need_div;
         lvl_ff  <= sts.need_div ? ref1 : '0;
         sold_ff <= sts.need_div && sold1;
      end
   end
   assign rsp_full      = full_ff && !rsp_take;
   assign out_valid     = full_ff;
   assign out_ref_valid = vld_ff;
   assign out_level     = lvl_ff;
   assign out_sold      = vld_ff ? sold_ff : 1'b0;

endmodule

>>> src/moving_average_band_trailing_reference.sv
// ----------------------------------------------------------------------------
// moving_average_band_trailing_reference: trailing band reference per series
// Keeps a moving window average per price series and reports a trailing
// reference level with a sold/unsold crossover state.
// ----------------------------------------------------------------------------
// Channel  Direction  Transfer content
// req_     in         tdata: series_index[6:0], close_price[38:7], zero pad
// rsp_     out        tdata: reference_valid[0], reference_level[33:1],
//                     sold_state[34], zero pad
// csr_     in         csr_index 0 window_days, 1 band_fraction
//
// One item at a time. An item whose series window is still filling, or whose
// series index is out of range, goes from its state read straight to commit.
// A started series and the first item after the window fills also pass the
// restoring divider, which produces one quotient bit per cycle over 38 bits
// and runs once (slid window average) or twice (old and slid averages),
// and the band multiply. The result appears in the same cycle as the block
// returns to idle and can take its next item. After reset and after each
// window_days write a clearing pass zeroes the series state; req_tready
// stays low meanwhile. A result waiting in the output register holds the
// block in its commit step until rsp_tready takes it.
module moving_average_band_trailing_reference #(
   parameter int NUM_SERIES = mabtr_pkg::NUM_SERIES_DEF,
   parameter int MAX_WINDOW = mabtr_pkg::MAX_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // series_index, close_price, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // reference_valid, reference_level, sold_state, pad
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mabtr_pkg::*;

   logic [WIN_W-1:0]  window_ff;
   logic [BAND_W-1:0] band_ff;
   logic              clear_req;

   // A window write clears every series, just as reset does.
   assign clear_req = csr_wen && (csr_index == CSR_WINDOW_DAYS);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         band_ff   <= BAND_RESET;
      end else if (csr_wen) begin
         if (csr_index == CSR_WINDOW_DAYS) begin
            window_ff <= csr_wdata[WIN_W-1:0];
         end else begin
            band_ff <= csr_wdata;
         end
      end
   end

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       rsp_full, out_ref_valid, out_sold;
   logic [REF_W-1:0] out_level;
   logic       rsp_take;

   assign rsp_take = rsp_tvalid && rsp_tready;

   mabtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_tvalid && req_tready),
      .rsp_full  (rsp_full),
      .clear_req (clear_req),
      .sts       (sts),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   mabtr_dpath #(
      .NUM_SERIES (NUM_SERIES),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .in_series     (req_tdata[6:0]),
      .in_price      (req_tdata[38:7]),
      .window_days   (window_ff),
      .band_fraction (band_ff),
      .rsp_take      (rsp_take),
      .rsp_full      (rsp_full),
      .out_valid     (rsp_tvalid),
      .out_ref_valid (out_ref_valid),
      .out_level     (out_level),
      .out_sold      (out_sold)
   );

   // Valid bit of the result is 1 exactly when a reference was produced.
   assign rsp_tdata = {5'd0, out_sold, out_level, out_ref_valid};

endmodule

>>> src/mabtr_checker.sv
// ----------------------------------------------------------------------------
// mabtr_checker: port-level checks
// Watches the top-level handshakes for stable results and exclusive work.
// ----------------------------------------------------------------------------
module mabtr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   // A result waiting for transfer must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // An accepted item is never followed by another in the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while busy");

   // A result never reports sold without a valid reference.
   a_sold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> rsp_tdata[0])
      else $error("sold without valid reference");

   // The pad bits stay zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == 5'd0)
      else $error("nonzero pad");
endmodule

bind moving_average_band_trailing_reference mabtr_checker u_chk (.*);
